### sv/c3f_pkg.sv
package c3f_pkg;

   // window geometry
   localparam int KERNEL_DIM = 3;
   localparam int WIN_TAPS   = KERNEL_DIM * KERNEL_DIM;
   localparam int MIN_DIM    = 3;

   // field and register widths
   localparam int COEF_BITS       = 16;
   localparam int KROW_BITS       = COEF_BITS * KERNEL_DIM;
   localparam int SUM_BITS        = 32;
   localparam int ROW_BITS        = 16;
   localparam int WIDTH_REG_BITS  = 11;
   localparam int HEIGHT_REG_BITS = 16;
   localparam int CSR_IDX_BITS    = 3;
   localparam int REQ_BITS        = 16;

   // register reset values
   localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 11'd1024;
   localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 16'd768;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CFG_IMAGE_WIDTH    = 3'd0,
      CFG_IMAGE_HEIGHT   = 3'd1,
      CFG_KERNEL_ROW_TOP = 3'd2,
      CFG_KERNEL_ROW_MID = 3'd3,
      CFG_KERNEL_ROW_BOT = 3'd4
   } cfg_reg_type;

   typedef logic [KROW_BITS-1:0] krow_type;

endpackage

### sv/c3f_mac.sv
// Multiply-accumulate pipeline: nine products, three row sums, final sum.
// Each stage only holds when the next one is full and stalled.
module c3f_mac #(
   parameter int PIXEL_BITS = 16,
   parameter int COL_BITS   = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [PIXEL_BITS-1:0]             win [c3f_pkg::WIN_TAPS],
   input  c3f_pkg::krow_type                 kernel [c3f_pkg::KERNEL_DIM],
   input  logic [COL_BITS-1:0]               in_col,
   input  logic [c3f_pkg::ROW_BITS-1:0]      in_row,
   input  logic                              in_last,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [c3f_pkg::SUM_BITS-1:0]      out_sum,
   output logic [COL_BITS-1:0]               out_col,
   output logic [c3f_pkg::ROW_BITS-1:0]      out_row,
   output logic                              out_last
);

   localparam int KD = c3f_pkg::KERNEL_DIM;
   localparam int SB = c3f_pkg::SUM_BITS;
   localparam int CB = c3f_pkg::COEF_BITS;

   logic [SB-1:0]            prod_ff [c3f_pkg::WIN_TAPS];
   logic [SB-1:0]            prod_in [c3f_pkg::WIN_TAPS];
   logic [SB-1:0]            rs_ff [KD];
   logic [SB-1:0]            rs_in [KD];
   logic                     v2_ff, v3_ff, ov_ff;
   logic [COL_BITS-1:0]      col2_ff, col3_ff, ocol_ff;
   logic [c3f_pkg::ROW_BITS-1:0] row2_ff, row3_ff, orow_ff;
   logic                     last2_ff, last3_ff, olast_ff;
   logic [SB-1:0]            osum_ff;
   logic                     r2, r3, rout;

   assign rout     = !ov_ff || out_ready;
   assign r3       = !v3_ff || rout;
   assign r2       = !v2_ff || r3;
   assign in_ready = r2;

   always_comb begin
      for (int r = 0; r < KD; r++) begin
         for (int c = 0; c < KD; c++) begin
            prod_in[r*KD+c] = SB'(kernel[r][c*CB +: CB]) * SB'(win[r*KD+c]);
         end
         rs_in[r] = prod_ff[r*KD] + prod_ff[r*KD+1] + prod_ff[r*KD+2];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         if (r2)   v2_ff <= in_valid;
         if (r3)   v3_ff <= v2_ff;
         if (rout) ov_ff <= v3_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (in_valid && r2) begin
         prod_ff  <= prod_in;
         col2_ff  <= in_col;
         row2_ff  <= in_row;
         last2_ff <= in_last;
      end
      if (v2_ff && r3) begin
         rs_ff    <= rs_in;
         col3_ff  <= col2_ff;
         row3_ff  <= row2_ff;
         last3_ff <= last2_ff;
      end
      if (v3_ff && rout) begin
         osum_ff  <= rs_ff[0] + rs_ff[1] + rs_ff[2];
         ocol_ff  <= col3_ff;
         orow_ff  <= row3_ff;
         olast_ff <= last3_ff;
      end
   end

   assign out_valid = ov_ff;
   assign out_sum   = osum_ff;
   assign out_col   = ocol_ff;
   assign out_row   = orow_ff;
   assign out_last  = olast_ff;

endmodule

### sv/conv3x3_image_filter_unit.sv
// Channel  | Dir | Handshake            | Word
// ---------+-----+----------------------+-----------------------------------------------
// req      | in  | req_tvalid/tready    | tdata[15:0] pixel
// rsp      | out | rsp_tvalid/tready    | tdata: filtered, out_col, out_row; tlast=frame_end
// csr      | in  | csr_we (no wait)     | csr_index, csr_wdata
//
// One pixel per clock sustained unless a stalled output backs up the pipe.
// A result passes the line store read, products, row sums and output register.
// The line store is a single 1024-entry memory read at accept and written
// back when its pixel leaves stage 1; consecutive pixels never share an address.
// Synchronous active-high reset clears counters, window and valid bits; the
// line store is not cleared. Stages hold only where the next stage is full
// and stalled, so pixels keep flowing while a result waits.
module conv3x3_image_filter_unit #(
   parameter int  MAX_WIDTH  = 1024,
   parameter int  PIXEL_BITS = 16,
   localparam int COL_BITS   = $clog2(MAX_WIDTH),
   localparam int RSP_BITS   =
      ((c3f_pkg::SUM_BITS + COL_BITS + c3f_pkg::ROW_BITS + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // pixel in
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [c3f_pkg::REQ_BITS-1:0]        req_tdata,  // [15:0] pixel
   // result out
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [RSP_BITS-1:0]                 rsp_tdata,  // filtered, out_col, out_row
   output logic                                rsp_tlast,  // frame_end
   // config writes
   input  logic                                csr_we,
   input  logic [c3f_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [c3f_pkg::KROW_BITS-1:0]       csr_wdata
);

   localparam int KD = c3f_pkg::KERNEL_DIM;
   localparam int RB = c3f_pkg::ROW_BITS;
   localparam int PB = PIXEL_BITS;

   // config registers
   logic [c3f_pkg::WIDTH_REG_BITS-1:0]  width_ff;
   logic [c3f_pkg::HEIGHT_REG_BITS-1:0] height_ff;
   c3f_pkg::krow_type                   kernel_ff [KD];

   // raster position of the next pixel
   logic [COL_BITS-1:0] col_ff, col_in;
   logic [RB-1:0]       row_ff, row_in;

   // stage 1: pixel waiting on line store data
   logic                v1_ff;
   logic [PB-1:0]       px1_ff;
   logic [COL_BITS-1:0] col1_ff;
   logic [RB-1:0]       row1_ff;
   logic                res1_ff, last1_ff;

   // line store: upper half = two rows up, lower half = one row up
   logic [2*PB-1:0]     line_mem [MAX_WIDTH];
   logic [2*PB-1:0]     line_rd_ff;

   logic [PB-1:0]       win_ff [c3f_pkg::WIN_TAPS];
   logic [PB-1:0]       win_in [c3f_pkg::WIN_TAPS];

   logic                accept, s1_retire, mac_ready;
   logic [15:0]         col_p1, width_cmp, height_eff;
   logic [RB:0]         row_p1;
   logic                last_col, last_row, has_res;
   logic [c3f_pkg::SUM_BITS-1:0] out_sum;
   logic [COL_BITS-1:0] out_col;
   logic [RB-1:0]       out_row;

   assign accept     = req_tvalid && req_tready;
   assign s1_retire  = v1_ff && (!res1_ff || mac_ready);
   assign req_tready = !v1_ff || s1_retire;

   // end-of-row / end-of-frame tests with clamped sizes
   always_comb begin
      col_p1     = 16'(col_ff) + 16'd1;
      width_cmp  = (width_ff < c3f_pkg::WIDTH_REG_BITS'(c3f_pkg::MIN_DIM))
                   ? 16'(c3f_pkg::MIN_DIM) : 16'(width_ff);
      last_col   = (col_p1 >= 16'(MAX_WIDTH)) || (col_p1 >= width_cmp);
      height_eff = (height_ff < 16'(c3f_pkg::MIN_DIM)) ? 16'(c3f_pkg::MIN_DIM)
                                                       : height_ff;
      row_p1     = {1'b0, row_ff} + (RB+1)'(1);
      last_row   = row_p1 >= {1'b0, height_eff};
      has_res    = (16'(col_ff) >= 16'(KD - 1)) && (row_ff >= RB'(KD - 1));
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : row_p1[RB-1:0];
      end else begin
         col_in = col_p1[COL_BITS-1:0];
         row_in = row_ff;
      end
   end

   // window shifts left, new column from line store and the pixel
   always_comb begin
      for (int r = 0; r < KD; r++) begin
         for (int c = 0; c < KD - 1; c++) begin
            win_in[r*KD+c] = win_ff[r*KD+c+1];
         end
      end
      win_in[KD-1]      = line_rd_ff[2*PB-1:PB];
      win_in[2*KD-1]    = line_rd_ff[PB-1:0];
      win_in[3*KD-1]    = px1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= c3f_pkg::WIDTH_RESET;
         height_ff <= c3f_pkg::HEIGHT_RESET;
         for (int r = 0; r < KD; r++) kernel_ff[r] <= '0;
         col_ff <= '0;
         row_ff <= '0;
         v1_ff  <= 1'b0;
         for (int i = 0; i < c3f_pkg::WIN_TAPS; i++) win_ff[i] <= '0;
      end else begin
         if (csr_we) begin
            unique case (c3f_pkg::cfg_reg_type'(csr_index))
               c3f_pkg::CFG_IMAGE_WIDTH:
                  width_ff <= csr_wdata[c3f_pkg::WIDTH_REG_BITS-1:0];
               c3f_pkg::CFG_IMAGE_HEIGHT:
                  height_ff <= csr_wdata[c3f_pkg::HEIGHT_REG_BITS-1:0];
               c3f_pkg::CFG_KERNEL_ROW_TOP: kernel_ff[0] <= csr_wdata;
               c3f_pkg::CFG_KERNEL_ROW_MID: kernel_ff[1] <= csr_wdata;
               c3f_pkg::CFG_KERNEL_ROW_BOT: kernel_ff[2] <= csr_wdata;
               default: ;  // unused index, dropped
            endcase
         end
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (req_tready) v1_ff <= req_tvalid;
         if (s1_retire)  win_ff <= win_in;
      end
   end

   // stage 1 payload
   always_ff @(posedge clock) begin
      if (accept) begin
         px1_ff   <= req_tdata[PB-1:0];
         col1_ff  <= col_ff;
         row1_ff  <= row_ff;
         res1_ff  <= has_res;
         last1_ff <= last_col && last_row;
      end
   end

   // line store: read on accept, write back when the pixel leaves stage 1
   always_ff @(posedge clock) begin
      if (accept) line_rd_ff <= line_mem[col_ff];
   end

   always_ff @(posedge clock) begin
      if (s1_retire) line_mem[col1_ff] <= {line_rd_ff[PB-1:0], px1_ff};
   end

   c3f_mac #(
      .PIXEL_BITS (PIXEL_BITS),
      .COL_BITS   (COL_BITS)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v1_ff && res1_ff),
      .in_ready  (mac_ready),
      .win       (win_in),
      .kernel    (kernel_ff),
      .in_col    (col1_ff - COL_BITS'(KD - 1)),
      .in_row    (row1_ff - RB'(KD - 1)),
      .in_last   (last1_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_sum   (out_sum),
      .out_col   (out_col),
      .out_row   (out_row),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = RSP_BITS'({out_row, out_col, out_sum});

endmodule

### sv/c3f_checker.sv
module c3f_checker #(
   parameter int COL_BITS = 10,
   parameter int RSP_BITS = 64
) (
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RSP_BITS-1:0] rsp_tdata,
   input logic                rsp_tlast
);

   localparam int SB = c3f_pkg::SUM_BITS;
   localparam int RB = c3f_pkg::ROW_BITS;

   // set while the next word opens a frame
   logic frame_start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_start_ff <= 1'b1;
      end else if (rsp_tvalid && rsp_tready) begin
         frame_start_ff <= rsp_tlast;
      end
   end

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result word changed");

   a_frame_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && frame_start_ff |->
         rsp_tdata[SB +: COL_BITS] == '0 && rsp_tdata[SB+COL_BITS +: RB] == '0)
      else $error("first word of a frame not at column 0, row 0");

   a_no_early_word: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 3) || !$past(rsp_tready, 1)
         || $past(rsp_tvalid, 1) == 1'b0 && $past(req_tvalid && req_tready, 4)
         || $past(req_tvalid && req_tready, 5) || $past(req_tvalid && req_tready, 6)
         || $past(req_tvalid && req_tready, 7))
      else $error("result word with no recent pixel accepted");

endmodule

bind conv3x3_image_filter_unit c3f_checker #(
   .COL_BITS ($clog2(MAX_WIDTH)),
   .RSP_BITS (((c3f_pkg::SUM_BITS + $clog2(MAX_WIDTH) + c3f_pkg::ROW_BITS + 7) / 8) * 8)
) u_c3f_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

### tb/tb_top.sv
module tb_top;
   import c3f_pkg::*;

   // ---------------------------------------------------------------------
   // Run shape
   // ---------------------------------------------------------------------
   localparam int LINE_DEPTH   = 1024;        // DUT MAX_WIDTH default
   localparam int COL_BITS     = $clog2(LINE_DEPTH);
   localparam int COL_LSB      = SUM_BITS;    // rsp_tdata: sum, col, row
   localparam int ROW_LSB      = SUM_BITS + COL_BITS;
   localparam int RSP_W        = ((SUM_BITS + COL_BITS + ROW_BITS + 7) / 8) * 8;
   localparam int PIPE_DRAIN   = 8;           // margin for results trailing their pixel
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int MAX_REPORTS  = 10;
   localparam int HOLD_CYCLES  = 400;         // long output stall, fills the pipe
   localparam int RANDOM_ITEMS = 800;
   localparam int CALM_TAIL    = 150;         // last random pixels run without gaps

   typedef struct packed {
      logic [SUM_BITS-1:0] filtered;
      logic [COL_BITS-1:0] out_col;
      logic [ROW_BITS-1:0] out_row;
      logic                frame_end;
   } filter_result_t;

   // ---------------------------------------------------------------------
   // DUT hookup
   // ---------------------------------------------------------------------
   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_BITS-1:0]     req_tdata;    // [15:0] pixel
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_W-1:0]        rsp_tdata;    // [31:0] filtered, [41:32] out_col, [57:42] out_row
   logic                    rsp_tlast;    // frame_end
   logic                    csr_we;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [KROW_BITS-1:0]    csr_wdata;

   conv3x3_image_filter_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Filter predictor state: register shadows, line stores, window, position
   // ---------------------------------------------------------------------
   logic [WIDTH_REG_BITS-1:0]  model_width;
   logic [HEIGHT_REG_BITS-1:0] model_height;
   krow_type                   model_kernel [KERNEL_DIM];
   logic [REQ_BITS-1:0]        line_prev    [LINE_DEPTH];   // row above
   logic [REQ_BITS-1:0]        line_prev2   [LINE_DEPTH];   // two rows above
   logic [REQ_BITS-1:0]        window_px    [WIN_TAPS];     // row-major, col 2 newest
   int unsigned                col_pos;
   int unsigned                row_pos;
   filter_result_t             window_sums_due [$];

   // bookkeeping
   bit          idle_on       = 1'b1;   // random gaps on both sides
   bit          offer_up      = 1'b0;   // mirror of what req_tvalid was last driven to
   bit          long_hold_req = 1'b0;   // ask the sink for one long stall
   int          stall_left;
   int unsigned mismatches;
   int unsigned results_seen;
   int unsigned pixels_sent;
   int unsigned frames_done;
   longint      cycle_count;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // One pixel through the predictor. A window sum is due once the pixel at
   // the window's bottom-right corner arrives (col >= 2 and row >= 2).
   function automatic void advance_filter(input logic [REQ_BITS-1:0] px);
      int unsigned         w;
      int unsigned         h;
      int unsigned         idx;
      logic [REQ_BITS-1:0] up1;
      logic [REQ_BITS-1:0] up2;
      logic [COEF_BITS-1:0] coef;
      logic [SUM_BITS-1:0] acc;
      bit                  row_done;
      bit                  frame_done;
      filter_result_t      res;
      // geometry saturates: width to 3..line length, height to at least 3
      w   = (model_width < MIN_DIM) ? MIN_DIM :
            (model_width > LINE_DEPTH) ? LINE_DEPTH : model_width;
      h   = (model_height < MIN_DIM) ? MIN_DIM : model_height;
      idx = (col_pos < LINE_DEPTH) ? col_pos : LINE_DEPTH - 1;
      up1 = line_prev[idx];
      up2 = line_prev2[idx];
      for (int r = 0; r < KERNEL_DIM; r++) begin
         for (int c = 0; c < KERNEL_DIM - 1; c++) begin
            window_px[r*KERNEL_DIM + c] = window_px[r*KERNEL_DIM + c + 1];
         end
      end
      window_px[KERNEL_DIM-1]     = up2;
      window_px[2*KERNEL_DIM-1]   = up1;
      window_px[WIN_TAPS-1]       = px;
      line_prev2[idx] = up1;
      line_prev[idx]  = px;
      row_done   = (col_pos + 1 >= w);
      frame_done = (row_pos + 1 >= h);
      if (col_pos >= KERNEL_DIM - 1 && row_pos >= KERNEL_DIM - 1) begin
         acc = '0;
         for (int t = 0; t < WIN_TAPS; t++) begin
            coef = model_kernel[t / KERNEL_DIM][(t % KERNEL_DIM)*COEF_BITS +: COEF_BITS];
            acc  = acc + {16'd0, coef} * {16'd0, window_px[t]};   // wraps at 32 bits
         end
         res.filtered  = acc;
         res.out_col   = COL_BITS'(col_pos - (KERNEL_DIM - 1));
         res.out_row   = ROW_BITS'(row_pos - (KERNEL_DIM - 1));
         res.frame_end = row_done && frame_done;
         window_sums_due.push_back(res);
      end
      // ">=" tests: a size change mid-frame closes the row/frame early
      if (row_done) begin
         col_pos = 0;
         if (frame_done) begin
            row_pos = 0;
            frames_done++;
         end else begin
            row_pos = row_pos + 1;
         end
      end else begin
         col_pos = col_pos + 1;
      end
   endfunction

   function automatic logic [KROW_BITS-1:0] rand_word48();
      return {16'($urandom), 32'($urandom)};
   endfunction

   // mostly uniform pixels, some rails, some dim values
   function automatic logic [REQ_BITS-1:0] pick_pixel();
      int unsigned sel;
      sel = $urandom_range(0, 19);
      if (sel < 14) return REQ_BITS'($urandom);
      if (sel < 17) return ($urandom_range(0, 1) != 0) ? '1 : '0;
      return REQ_BITS'($urandom_range(0, 255));
   endfunction

   function automatic krow_type pick_kernel_row();
      krow_type    row;
      int unsigned sel;
      sel = $urandom_range(0, 5);
      if (sel < 3) return rand_word48();
      if (sel == 3) return '1;
      if (sel == 5) return '0;
      for (int c = 0; c < KERNEL_DIM; c++) begin
         row[c*COEF_BITS +: COEF_BITS] = COEF_BITS'($urandom_range(0, 3));
      end
      return row;
   endfunction

   // ---------------------------------------------------------------------
   // Pixel sender: optional random gap, then hold the word until accepted.
   // Valid stays up between back-to-back words.
   // ---------------------------------------------------------------------
   task automatic send_pixel(input logic [REQ_BITS-1:0] px);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         if (offer_up) req_tvalid <= 1'b0;
         offer_up = 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      offer_up    = 1'b1;
      do @(posedge clock); while (!req_tready);
      advance_filter(px);
      pixels_sent++;
   endtask

   task automatic send_pixels(input int unsigned count);
      repeat (count) send_pixel(pick_pixel());
   endtask

   // keep sending until the predictor wraps back to the top-left pixel
   task automatic finish_frame();
      do send_pixel(pick_pixel()); while (col_pos != 0 || row_pos != 0);
   endtask

   // Drop valid, wait for every due word, then allow for pixels still in
   // flight that produce no word.
   task automatic settle_pipeline();
      req_tvalid <= 1'b0;
      offer_up    = 1'b0;
      @(posedge clock);
      while (window_sums_due.size() != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   task automatic write_reg(input cfg_reg_type idx, input logic [KROW_BITS-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CFG_IMAGE_WIDTH:    model_width     = val[WIDTH_REG_BITS-1:0];
         CFG_IMAGE_HEIGHT:   model_height    = val[HEIGHT_REG_BITS-1:0];
         CFG_KERNEL_ROW_TOP: model_kernel[0] = val;
         CFG_KERNEL_ROW_MID: model_kernel[1] = val;
         CFG_KERNEL_ROW_BOT: model_kernel[2] = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_geometry(input int unsigned w, input int unsigned h);
      write_reg(CFG_IMAGE_WIDTH,  KROW_BITS'(w));
      write_reg(CFG_IMAGE_HEIGHT, KROW_BITS'(h));
   endtask

   task automatic load_kernel(input krow_type top, input krow_type mid, input krow_type bot);
      write_reg(CFG_KERNEL_ROW_TOP, top);
      write_reg(CFG_KERNEL_ROW_MID, mid);
      write_reg(CFG_KERNEL_ROW_BOT, bot);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset geometry is a full 1024-pixel line. Two lines plus a bit of the
   // third go in with the reset (all-zero) kernel, so those sums are zero.
   // Then a kernel is loaded and the height cut to 3 so row 2 ends the frame.
   task automatic test_reset_defaults();
      send_pixels(2 * LINE_DEPTH + 12);
      settle_pipeline();
      load_kernel(rand_word48(), rand_word48(), rand_word48());
      write_reg(CFG_IMAGE_HEIGHT, KROW_BITS'(MIN_DIM));
      finish_frame();
      settle_pipeline();
   endtask

   // Smallest frame, rails on pixels and coefficients (sum wraps), then a
   // kernel with a distinct weight per tap to pin down tap placement.
   task automatic test_value_extremes();
      set_geometry(MIN_DIM, MIN_DIM);
      load_kernel('1, '1, '1);
      repeat (WIN_TAPS) send_pixel('1);
      repeat (WIN_TAPS) send_pixel('0);
      settle_pipeline();
      load_kernel(48'h0004_0002_0001, 48'h0020_0010_0008, 48'h0100_0080_0040);
      finish_frame();
      settle_pipeline();
   endtask

   // Width/height below 3 saturate up; width above a line saturates down.
   // Tallest height is cut mid-frame after the row count has passed it.
   task automatic test_size_saturation();
      set_geometry(0, 2);
      finish_frame();
      settle_pipeline();
      set_geometry(2, 0);
      finish_frame();
      settle_pipeline();
      set_geometry(11'h7FF, 16'hFFFF);
      send_pixels(5);
      settle_pipeline();
      write_reg(CFG_IMAGE_WIDTH, KROW_BITS'(MIN_DIM));   // col 5 is past it: row closes
      send_pixels(1 + 4 * MIN_DIM);
      settle_pipeline();
      write_reg(CFG_IMAGE_HEIGHT, 48'd4);                // already on row 5
      finish_frame();
      settle_pipeline();
   endtask

   // Kernel swap mid-frame, then the width cut so the current column ends the
   // row and the height cut under the current row, then the width grown back at a frame start.
   task automatic test_midframe_changes();
      set_geometry(6, 6);
      load_kernel(pick_kernel_row(), pick_kernel_row(), pick_kernel_row());
      send_pixels(15);
      settle_pipeline();
      write_reg(CFG_KERNEL_ROW_MID, rand_word48());
      send_pixels(6);
      settle_pipeline();
      write_reg(CFG_IMAGE_WIDTH, 48'd4);
      write_reg(CFG_IMAGE_HEIGHT, 48'd2);
      finish_frame();
      settle_pipeline();
      set_geometry(6, 4);
      finish_frame();
      settle_pipeline();
   endtask

   // Sink stalls for a long stretch while pixels keep coming: the pipe
   // fills and req_tready must drop without losing or duplicating words.
   task automatic test_input_backpressure();
      set_geometry(8, 40);
      load_kernel(rand_word48(), rand_word48(), rand_word48());
      long_hold_req = 1'b1;
      finish_frame();
      settle_pipeline();
   endtask

   // Random frames, mostly small. About one in five gets a kernel swap, a
   // width cut or a height change part way through. Width never grows
   // mid-frame: that would read line store entries the frame never wrote.
   task automatic test_random_frames();
      int unsigned start;
      int unsigned w;
      int unsigned h;
      int unsigned eff_w;
      int unsigned eff_h;
      logic [KROW_BITS-1:0] v;
      start = pixels_sent;
      while (pixels_sent - start < RANDOM_ITEMS) begin
         if (pixels_sent - start >= RANDOM_ITEMS - CALM_TAIL) idle_on = 1'b0;
         w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
         h = $urandom_range(0, 6);
         eff_w = (w < MIN_DIM) ? MIN_DIM : w;
         eff_h = (h < MIN_DIM) ? MIN_DIM : h;
         // unused upper register bits carry junk
         v = rand_word48();
         v[WIDTH_REG_BITS-1:0] = WIDTH_REG_BITS'(w);
         write_reg(CFG_IMAGE_WIDTH, v);
         v = rand_word48();
         v[HEIGHT_REG_BITS-1:0] = HEIGHT_REG_BITS'(h);
         write_reg(CFG_IMAGE_HEIGHT, v);
         if ($urandom_range(0, 2) != 0) begin
            load_kernel(pick_kernel_row(), pick_kernel_row(), pick_kernel_row());
         end
         if ($urandom_range(0, 4) == 0) begin
            send_pixels($urandom_range(1, eff_w * eff_h - 1));
            settle_pipeline();
            case ($urandom_range(0, 2))
               0: write_reg(cfg_reg_type'(CFG_KERNEL_ROW_TOP + $urandom_range(0, 2)),
                            pick_kernel_row());
               1: write_reg(CFG_IMAGE_WIDTH, KROW_BITS'($urandom_range(0, eff_w)));
               default: write_reg(CFG_IMAGE_HEIGHT, KROW_BITS'($urandom_range(0, 8)));
            endcase
         end
         finish_frame();
         settle_pipeline();
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_index  <= CFG_IMAGE_WIDTH;
      csr_wdata  <= '0;
      model_width  = WIDTH_RESET;
      model_height = HEIGHT_RESET;
      for (int i = 0; i < KERNEL_DIM; i++) model_kernel[i] = '0;
      for (int i = 0; i < LINE_DEPTH; i++) begin
         line_prev[i]  = '0;
         line_prev2[i] = '0;
      end
      for (int i = 0; i < WIN_TAPS; i++) window_px[i] = '0;
      col_pos = 0;
      row_pos = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_value_extremes();
      test_size_saturation();
      test_midframe_changes();
      test_input_backpressure();
      test_random_frames();
      settle_pipeline();

      $display("run covered %0d pixels in %0d frames and checked %0d result words",
               pixels_sent, frames_done, results_seen);
      $display("incl. reset geometry, size saturation, mid-frame changes, long output stall");
      if (mismatches == 0) begin
         $display("conv3x3_image_filter_unit: match");
      end else begin
         $display("conv3x3_image_filter_unit: mismatch");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Result sink: random stall bursts, plus one long hold on request, counted here.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (long_hold_req) begin
         long_hold_req = 1'b0;
         rsp_tready <= 1'b0;
         stall_left <= HOLD_CYCLES;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 11);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Every accepted word against the oldest due window sum.
   always @(posedge clock) begin
      filter_result_t got;
      filter_result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.filtered  = rsp_tdata[SUM_BITS-1:0];
         got.out_col   = rsp_tdata[COL_LSB +: COL_BITS];
         got.out_row   = rsp_tdata[ROW_LSB +: ROW_BITS];
         got.frame_end = rsp_tlast;
         results_seen++;
         if (window_sums_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("ERROR @%0t: unexpected word sum %h col %0d row %0d last %0b",
                        $realtime, got.filtered, got.out_col, got.out_row, got.frame_end);
            end
         end else begin
            want = window_sums_due.pop_front();
            if (got.filtered !== want.filtered || got.out_col !== want.out_col ||
                got.out_row !== want.out_row || got.frame_end !== want.frame_end) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("ERROR @%0t: want sum %h col %0d row %0d last %0b", $realtime,
                           want.filtered, want.out_col, want.out_row, want.frame_end);
                  $display("               got sum %h col %0d row %0d last %0b",
                           got.filtered, got.out_col, got.out_row, got.frame_end);
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still due",
                  cycle_count, window_sums_due.size());
         $display("conv3x3_image_filter_unit: mismatch");
         $finish;
      end
   end

endmodule
